[design/dual_issue_pairing_hazard_unit_macros.svh]
// ----------------------------------------------------------------------------
// dual issue pairing hazard unit assertion macros
// concurrent checks used by the port checker
// ----------------------------------------------------------------------------
`ifndef DUAL_ISSUE_PAIRING_HAZARD_UNIT_MACROS_SVH
`define DUAL_ISSUE_PAIRING_HAZARD_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define DIPU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dipu check failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define DIPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dipu check failed: next-cycle implication");

`endif

[design/dipu_pkg.sv]
// ----------------------------------------------------------------------------
// dipu_pkg
// types, kind and cause codes, and pairing / hazard helper functions
// ----------------------------------------------------------------------------
`default_nettype none

package dipu_pkg;

    localparam int KIND_W  = 4;
    localparam int REG_W   = 8;
    localparam int PC_W    = 32;
    localparam int CAUSE_W = 2;

    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam int CMD_DEPTH = 2;
    localparam int CMD_IDX_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam logic [PC_W-1:0] PC_STEP = PC_W'(4);

    // instruction kinds
    localparam logic [KIND_W-1:0] KIND_NOP     = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_RTYPE   = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_ITYPE   = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_LOAD    = KIND_W'(3);
    localparam logic [KIND_W-1:0] KIND_STORE   = KIND_W'(4);
    localparam logic [KIND_W-1:0] KIND_BRANCH  = KIND_W'(5);
    localparam logic [KIND_W-1:0] KIND_JUMP    = KIND_W'(6);
    localparam logic [KIND_W-1:0] KIND_SPECIAL = KIND_W'(7);
    localparam logic [KIND_W-1:0] KIND_JR      = KIND_W'(8);

    // bubble causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE     = CAUSE_W'(0);
    localparam logic [CAUSE_W-1:0] CAUSE_LOAD_USE = CAUSE_W'(1);
    localparam logic [CAUSE_W-1:0] CAUSE_CONTROL  = CAUSE_W'(2);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REG_W-1:0]  src_a;
        logic [REG_W-1:0]  src_b;
        logic [REG_W-1:0]  dst;
        logic [PC_W-1:0]   pc;
    } slot_t;

    localparam slot_t NOP_SLOT = '0;

    // one pipe advance request from the front to the back
    typedef struct packed {
        slot_t first;
        slot_t second;
        logic  step_end;   // last advance of this input if drain is clear; with drain set, drain advances follow
        logic  drain;      // final input: drain the pipe after this advance
    } cmd_t;

    function automatic logic is_mem(input logic [KIND_W-1:0] k);
        return (k == KIND_LOAD) || (k == KIND_STORE);
    endfunction

    function automatic logic reads_two(input logic [KIND_W-1:0] k);
        return (k == KIND_RTYPE) || (k == KIND_STORE) || (k == KIND_BRANCH);
    endfunction

    function automatic logic reads_one(input logic [KIND_W-1:0] k);
        return (k == KIND_ITYPE) || (k == KIND_JR) || (k == KIND_LOAD);
    endfunction

    function automatic logic writes_dst(input logic [KIND_W-1:0] k);
        return (k == KIND_RTYPE) || (k == KIND_ITYPE) || (k == KIND_LOAD);
    endfunction

    function automatic logic reads_reg(input slot_t s, input logic [REG_W-1:0] r);
        logic hit;
        hit = 1'b0;
        if (reads_two(s.kind))
        begin
            hit = (s.src_a == r) || (s.src_b == r);
        end
        else if (reads_one(s.kind))
        begin
            hit = (s.src_a == r);
        end
        return hit;
    endfunction

    function automatic logic can_pair(input slot_t a, input slot_t b);
        logic ok;
        ok = (is_mem(a.kind) != is_mem(b.kind));
        if (writes_dst(a.kind) && reads_reg(b, a.dst))
        begin
            ok = 1'b0;
        end
        if ((a.kind == KIND_BRANCH) || (a.kind == KIND_JUMP) || (a.kind == KIND_JR))
        begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    // hazard between the decode pair and the fetch pair
    function automatic logic [CAUSE_W-1:0] hazard(input slot_t d0, input slot_t d1,
                                                  input slot_t f0, input slot_t f1,
                                                  input logic fetch_valid);
        logic [CAUSE_W-1:0] cause;
        logic [REG_W-1:0]   load_dst;
        cause    = CAUSE_NONE;
        load_dst = (d0.kind == KIND_LOAD) ? d0.dst : d1.dst;
        if (((d0.kind == KIND_LOAD) || (d1.kind == KIND_LOAD)) &&
            (reads_reg(f0, load_dst) || reads_reg(f1, load_dst)))
        begin
            cause = CAUSE_LOAD_USE;
        end
        else if (fetch_valid)
        begin
            if (d0.kind == KIND_BRANCH)
            begin
                if (f0.pc != PC_W'(d0.pc + PC_STEP))
                begin
                    cause = CAUSE_CONTROL;
                end
            end
            else if (d1.kind == KIND_BRANCH)
            begin
                if (f0.pc != PC_W'(d1.pc + PC_STEP))
                begin
                    cause = CAUSE_CONTROL;
                end
            end
        end
        return cause;
    endfunction

endpackage

`default_nettype wire

[design/dipu_if.sv]
// ----------------------------------------------------------------------------
// dipu interfaces
// valid/ready channels for incoming instructions and issued slot pairs
// ----------------------------------------------------------------------------
`default_nettype none

interface dipu_in_if;
    logic                          valid;
    logic                          ready;
    logic [dipu_pkg::KIND_W-1:0]   instr_kind;
    logic [dipu_pkg::REG_W-1:0]    src_reg_a;
    logic [dipu_pkg::REG_W-1:0]    src_reg_b;
    logic [dipu_pkg::REG_W-1:0]    dest_reg;
    logic [dipu_pkg::PC_W-1:0]     instr_pc;
    logic                          end_of_trace;

    modport source (output valid, instr_kind, src_reg_a, src_reg_b, dest_reg, instr_pc,
                    end_of_trace, input ready);
    modport sink (input valid, instr_kind, src_reg_a, src_reg_b, dest_reg, instr_pc,
                  end_of_trace, output ready);
endinterface

interface dipu_out_if;
    logic                          valid;
    logic                          ready;
    logic [dipu_pkg::KIND_W-1:0]   alu_slot_kind;
    logic [dipu_pkg::PC_W-1:0]     alu_slot_pc;
    logic [dipu_pkg::KIND_W-1:0]   mem_slot_kind;
    logic [dipu_pkg::PC_W-1:0]     mem_slot_pc;
    logic [dipu_pkg::CAUSE_W-1:0]  bubble_cause;
    logic                          last_cycle;

    modport source (output valid, alu_slot_kind, alu_slot_pc, mem_slot_kind, mem_slot_pc,
                    bubble_cause, last_cycle, input ready);
    modport sink (input valid, alu_slot_kind, alu_slot_pc, mem_slot_kind, mem_slot_pc,
                  bubble_cause, last_cycle, output ready);
endinterface

`default_nettype wire

[design/dipu_front.sv]
// ----------------------------------------------------------------------------
// dipu_front
// holds one instruction back, pairs it with the next and queues advances
// ----------------------------------------------------------------------------
`default_nettype none

module dipu_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    dipu_in_if.sink           instr,
    output dipu_pkg::cmd_t    push_cmd,
    output logic              push,
    input  wire logic         q_full
);

    dipu_pkg::slot_t held_reg;
    dipu_pkg::slot_t held_next;
    logic            held_valid_reg;
    logic            held_valid_next;
    logic            flush_reg;
    logic            flush_next;
    dipu_pkg::slot_t x;
    logic            accept;
    logic            last;

    assign x.kind  = instr.instr_kind;
    assign x.src_a = instr.src_reg_a;
    assign x.src_b = instr.src_reg_b;
    assign x.dst   = instr.dest_reg;
    assign x.pc    = instr.instr_pc;
    assign last    = instr.end_of_trace;

    assign instr.ready = !flush_reg && !q_full;
    assign accept      = instr.valid && instr.ready;

    always_comb
    begin
        push            = 1'b0;
        push_cmd        = '0;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        flush_next      = flush_reg;
        priority if (flush_reg)
        begin
            // second half of a final input that could not pair
            if (!q_full)
            begin
                push                = 1'b1;
                push_cmd.first      = held_reg;
                push_cmd.second     = dipu_pkg::NOP_SLOT;
                push_cmd.step_end   = 1'b1;
                push_cmd.drain      = 1'b1;
                held_valid_next     = 1'b0;
                flush_next          = 1'b0;
            end
        end
        else if (accept)
        begin
            priority if (!held_valid_reg)
            begin
                if (last)
                begin
                    push              = 1'b1;
                    push_cmd.first    = x;
                    push_cmd.second   = dipu_pkg::NOP_SLOT;
                    push_cmd.step_end = 1'b1;
                    push_cmd.drain    = 1'b1;
                end
                else
                begin
                    held_next       = x;
                    held_valid_next = 1'b1;
                end
            end
            else if (dipu_pkg::can_pair(held_reg, x))
            begin
                push              = 1'b1;
                push_cmd.first    = held_reg;
                push_cmd.second   = x;
                push_cmd.step_end = 1'b1;
                push_cmd.drain    = last;
                held_valid_next   = 1'b0;
            end
            else
            begin
                push              = 1'b1;
                push_cmd.first    = held_reg;
                push_cmd.second   = dipu_pkg::NOP_SLOT;
                push_cmd.step_end = !last;
                push_cmd.drain    = 1'b0;
                held_next         = x;
                flush_next        = last;
            end
        end
        else
        begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            flush_reg      <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            flush_reg      <= flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

`default_nettype wire

[design/dipu_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// dipu_cmd_fifo
// short queue of advance requests between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module dipu_cmd_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire dipu_pkg::cmd_t  push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output dipu_pkg::cmd_t       head,
    output logic                 not_empty
);

    dipu_pkg::cmd_t                       entry_reg [dipu_pkg::CMD_DEPTH];
    logic [dipu_pkg::CMD_IDX_W-1:0]       wr_ptr_reg;
    logic [dipu_pkg::CMD_IDX_W-1:0]       rd_ptr_reg;
    logic [dipu_pkg::CMD_CNT_W-1:0]       count_reg;
    logic                                 do_push;
    logic                                 do_pop;

    assign full      = (count_reg == dipu_pkg::CMD_CNT_W'(dipu_pkg::CMD_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == dipu_pkg::CMD_IDX_W'(dipu_pkg::CMD_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == dipu_pkg::CMD_IDX_W'(dipu_pkg::CMD_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[design/dipu_back.sv]
// ----------------------------------------------------------------------------
// dipu_back
// fetch/decode pair pipe, hazard bubbles, drain and issue slot split
// ----------------------------------------------------------------------------
`default_nettype none

module dipu_back #(
    parameter int DRAIN_CYCLES = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dipu_pkg::cmd_t  head,
    input  wire logic            not_empty,
    output logic                 pop,
    dipu_out_if.source           issue
);

    localparam int DRAIN_W = $clog2(DRAIN_CYCLES + 1);

    dipu_pkg::slot_t                 dec0_reg;
    dipu_pkg::slot_t                 dec1_reg;
    dipu_pkg::slot_t                 fet0_reg;
    dipu_pkg::slot_t                 fet1_reg;
    logic [dipu_pkg::CAUSE_W-1:0]    pend_cause_reg;
    logic                            pend_last_reg;
    logic [DRAIN_W-1:0]              drain_cnt_reg;
    logic [dipu_pkg::RES_CNT_W-1:0]  res_cnt_reg;
    logic                            out_valid_reg;
    logic [dipu_pkg::KIND_W-1:0]     alu_kind_reg;
    logic [dipu_pkg::PC_W-1:0]       alu_pc_reg;
    logic [dipu_pkg::KIND_W-1:0]     mem_kind_reg;
    logic [dipu_pkg::PC_W-1:0]       mem_pc_reg;
    logic [dipu_pkg::CAUSE_W-1:0]    cause_out_reg;
    logic                            last_out_reg;

    logic                            src_stall;
    logic                            src_drain;
    logic                            src_cmd;
    logic                            fire;
    dipu_pkg::slot_t                 new0;
    dipu_pkg::slot_t                 new1;
    logic                            new_fv;
    logic [dipu_pkg::CAUSE_W-1:0]    hz;
    logic                            adv_last;
    logic                            step_last;
    logic [dipu_pkg::CAUSE_W-1:0]    cause;
    logic                            visible;
    dipu_pkg::slot_t                 alu_slot;
    dipu_pkg::slot_t                 mem_slot;

    always_comb
    begin
        // a pending bubble goes first, then drain advances, then queued advances
        src_stall = (pend_cause_reg != dipu_pkg::CAUSE_NONE);
        src_drain = !src_stall && (drain_cnt_reg != '0);
        src_cmd   = !src_stall && !src_drain && not_empty;
        fire      = (src_stall || src_drain || src_cmd) && (!out_valid_reg || issue.ready);
        pop       = fire && src_cmd;

        new0   = src_cmd ? head.first  : dipu_pkg::NOP_SLOT;
        new1   = src_cmd ? head.second : dipu_pkg::NOP_SLOT;
        new_fv = src_cmd;
        hz     = dipu_pkg::hazard(fet0_reg, fet1_reg, new0, new1, new_fv);

        adv_last  = src_cmd ? (head.step_end && !head.drain)
                            : (drain_cnt_reg == DRAIN_W'(1));
        step_last = src_stall ? pend_last_reg
                              : (adv_last && (hz == dipu_pkg::CAUSE_NONE));
        cause     = src_stall ? pend_cause_reg : dipu_pkg::CAUSE_NONE;
        visible   = (res_cnt_reg < dipu_pkg::RES_CNT_W'(dipu_pkg::MAX_RESULTS));

        if (dipu_pkg::is_mem(dec0_reg.kind))
        begin
            alu_slot = dec1_reg;
            mem_slot = dec0_reg;
        end
        else
        begin
            alu_slot = dec0_reg;
            mem_slot = dec1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec0_reg       <= dipu_pkg::NOP_SLOT;
            dec1_reg       <= dipu_pkg::NOP_SLOT;
            fet0_reg       <= dipu_pkg::NOP_SLOT;
            fet1_reg       <= dipu_pkg::NOP_SLOT;
            pend_cause_reg <= dipu_pkg::CAUSE_NONE;
            pend_last_reg  <= 1'b0;
            drain_cnt_reg  <= '0;
            res_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            alu_kind_reg   <= '0;
            alu_pc_reg     <= '0;
            mem_kind_reg   <= '0;
            mem_pc_reg     <= '0;
            cause_out_reg  <= dipu_pkg::CAUSE_NONE;
            last_out_reg   <= 1'b0;
        end
        else
        begin
            if (issue.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                if (src_stall)
                begin
                    // bubble: decode issues and becomes no-ops, fetch holds
                    dec0_reg       <= dipu_pkg::NOP_SLOT;
                    dec1_reg       <= dipu_pkg::NOP_SLOT;
                    pend_cause_reg <= dipu_pkg::CAUSE_NONE;
                end
                else
                begin
                    dec0_reg       <= fet0_reg;
                    dec1_reg       <= fet1_reg;
                    fet0_reg       <= new0;
                    fet1_reg       <= new1;
                    pend_cause_reg <= hz;
                    pend_last_reg  <= adv_last;
                    if (src_drain)
                    begin
                        drain_cnt_reg <= drain_cnt_reg - 1'b1;
                    end
                    else if (head.drain)
                    begin
                        drain_cnt_reg <= DRAIN_W'(DRAIN_CYCLES);
                    end
                end

                if (step_last)
                begin
                    res_cnt_reg <= '0;
                end
                else if (visible)
                begin
                    res_cnt_reg <= res_cnt_reg + 1'b1;
                end

                if (visible)
                begin
                    out_valid_reg <= 1'b1;
                    alu_kind_reg  <= alu_slot.kind;
                    alu_pc_reg    <= alu_slot.pc;
                    mem_kind_reg  <= mem_slot.kind;
                    mem_pc_reg    <= mem_slot.pc;
                    cause_out_reg <= cause;
                    last_out_reg  <= step_last ||
                        (res_cnt_reg == dipu_pkg::RES_CNT_W'(dipu_pkg::MAX_RESULTS - 1));
                end
            end
        end
    end

    assign issue.valid         = out_valid_reg;
    assign issue.alu_slot_kind = alu_kind_reg;
    assign issue.alu_slot_pc   = alu_pc_reg;
    assign issue.mem_slot_kind = mem_kind_reg;
    assign issue.mem_slot_pc   = mem_pc_reg;
    assign issue.bubble_cause  = cause_out_reg;
    assign issue.last_cycle    = last_out_reg;

endmodule

`default_nettype wire

[design/dual_issue_pairing_hazard_unit.sv]
// ----------------------------------------------------------------------------
// dual_issue_pairing_hazard_unit
// throughput: one instruction per cycle while ready is high; each load-use or control bubble adds a transfer
// output: a queued advance loads its issued decode pair into the output register as it is dequeued
// final instruction: up to two advances plus DRAIN_CYCLES drain advances, one per cycle unless the output stalls
// reset: asynchronous active low; holding slot empty, fetch and decode pairs to no-ops
// ----------------------------------------------------------------------------
`default_nettype none

module dual_issue_pairing_hazard_unit #(
    parameter int DRAIN_CYCLES = 4
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    dipu_in_if.sink      instr,
    dipu_out_if.source   issue
);

    // front side: holding slot and pairing rules; it turns each accepted
    // instruction into zero, one or two pipe advances (two only when a final
    // instruction cannot pair, and then ready stays low until the second is queued)
    dipu_pkg::cmd_t push_cmd;
    logic           push;
    logic           q_full;

    // back side: fetch and decode pair registers; each advance issues the
    // decode pair, and a hazard found on the new fetch/decode contents costs
    // one bubble transfer before the next advance
    dipu_pkg::cmd_t head;
    logic           not_empty;
    logic           pop;

    dipu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .instr    (instr),
        .push_cmd (push_cmd),
        .push     (push),
        .q_full   (q_full)
    );

    // two-entry queue lets the front keep taking instructions while the
    // back issues a bubble or waits on the output
    dipu_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    // the back also expands a final instruction into drain advances and
    // caps the transfers of one instruction at the result limit, marking
    // the last one with last_cycle
    dipu_back #(
        .DRAIN_CYCLES (DRAIN_CYCLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .issue     (issue)
    );

endmodule

`default_nettype wire

[design/dipu_checker.sv]
// ----------------------------------------------------------------------------
// dipu_checker
// port-level checks on issued slot pairs, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_issue_pairing_hazard_unit_macros.svh"

module dipu_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [dipu_pkg::KIND_W-1:0]   alu_slot_kind,
    input  wire logic [dipu_pkg::PC_W-1:0]     alu_slot_pc,
    input  wire logic [dipu_pkg::KIND_W-1:0]   mem_slot_kind,
    input  wire logic [dipu_pkg::PC_W-1:0]     mem_slot_pc,
    input  wire logic [dipu_pkg::CAUSE_W-1:0]  bubble_cause
);

    logic xfer;
    logic after_bubble_reg;

    assign xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_bubble_reg <= 1'b0;
        end
        else if (xfer)
        begin
            after_bubble_reg <= (bubble_cause != dipu_pkg::CAUSE_NONE);
        end
    end

    // a result waiting on the sink stays offered
    `DIPU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // a load-use bubble issues the pair that holds the load
    `DIPU_ASSERT_NOW(a_load_use_load, clk, rst_n, out_valid && bubble_cause == dipu_pkg::CAUSE_LOAD_USE, alu_slot_kind == dipu_pkg::KIND_LOAD || mem_slot_kind == dipu_pkg::KIND_LOAD)

    // a control bubble issues the pair that holds the branch
    `DIPU_ASSERT_NOW(a_control_branch, clk, rst_n, out_valid && bubble_cause == dipu_pkg::CAUSE_CONTROL, alu_slot_kind == dipu_pkg::KIND_BRANCH || mem_slot_kind == dipu_pkg::KIND_BRANCH)

    // the transfer after a bubble issues the emptied decode pair
    `DIPU_ASSERT_NOW(a_empty_after_bubble, clk, rst_n, xfer && after_bubble_reg, alu_slot_kind == dipu_pkg::KIND_NOP && mem_slot_kind == dipu_pkg::KIND_NOP && alu_slot_pc == '0 && mem_slot_pc == '0)

endmodule

bind dual_issue_pairing_hazard_unit dipu_checker u_dipu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (issue.valid),
    .out_ready     (issue.ready),
    .alu_slot_kind (issue.alu_slot_kind),
    .alu_slot_pc   (issue.alu_slot_pc),
    .mem_slot_kind (issue.mem_slot_kind),
    .mem_slot_pc   (issue.mem_slot_pc),
    .bubble_cause  (issue.bubble_cause)
);

`default_nettype wire

[tb/sv/dual_issue_pairing_hazard_unit_tb.sv]
// ----------------------------------------------------------------------------
// dual_issue_pairing_hazard_unit_tb
// drives instructions in program order and checks every issued alu / memory
// slot pair against a cycle-level prediction of pairing, hazards and drain
// ----------------------------------------------------------------------------
module dual_issue_pairing_hazard_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dipu_pkg::*;

    localparam int DRAIN_CYCLES = 4;
    localparam int RUN_LIMIT    = 400_000;   // cycles, far above the slowest legal run
    localparam int HOLD_CYCLES  = 200;       // long receiver hold-off
    localparam int RESET_CYCLES = 12;

    // kinds outside the defined set, passed through untouched
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_LO = KIND_W'(9);
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_HI = KIND_W'(15);

    // one issued slot pair as seen on the output channel
    typedef struct packed {
        logic [KIND_W-1:0]  alu_kind;
        logic [PC_W-1:0]    alu_pc;
        logic [KIND_W-1:0]  mem_kind;
        logic [PC_W-1:0]    mem_pc;
        logic [CAUSE_W-1:0] cause;
        logic               last;
    } slot_pair_t;

    logic clk;
    logic rst_n;

    dipu_in_if  instr_bus();
    dipu_out_if issue_bus();

    dual_issue_pairing_hazard_unit #(
        .DRAIN_CYCLES(DRAIN_CYCLES)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .instr (instr_bus),
        .issue (issue_bus)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // pipeline prediction: its own copy of holding slot, fetch and decode pairs
    // ------------------------------------------------------------------------
    slot_t      held_slot;
    bit         held_full  = 1'b0;
    slot_t      fetch_q [2] = '{NOP_SLOT, NOP_SLOT};
    slot_t      decode_q[2] = '{NOP_SLOT, NOP_SLOT};
    bit         fetch_full = 1'b0;

    slot_pair_t step_pairs[$];      // pairs caused by the instruction in flight
    slot_pair_t expected_pairs[$];  // pairs still owed by the block, oldest first

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_requests = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    logic [PC_W-1:0] program_pc = '0;

    function automatic bit touches_memory(logic [KIND_W-1:0] k);
        return (k == KIND_LOAD) || (k == KIND_STORE);
    endfunction

    function automatic bit writes_register(logic [KIND_W-1:0] k);
        return k inside {KIND_RTYPE, KIND_ITYPE, KIND_LOAD};
    endfunction

    // itype, load and jump register read src a only; rtype, store, branch read both
    function automatic bit reads_register(slot_t s, logic [REG_W-1:0] r);
        case (s.kind)
            KIND_RTYPE, KIND_STORE, KIND_BRANCH: return (s.src_a == r) || (s.src_b == r);
            KIND_ITYPE, KIND_LOAD, KIND_JR:      return s.src_a == r;
            default:                             return 1'b0;
        endcase
    endfunction

    // exactly one memory op, no control op first, no read of the first's destination
    function automatic bit pairable(slot_t first, slot_t second);
        if (touches_memory(first.kind) == touches_memory(second.kind))
        begin
            return 1'b0;
        end
        if (first.kind inside {KIND_BRANCH, KIND_JUMP, KIND_JR})
        begin
            return 1'b0;
        end
        return !(writes_register(first.kind) && reads_register(second, first.dst));
    endfunction

    // load-use has priority over a control mismatch
    function automatic logic [CAUSE_W-1:0] bubble_reason();
        logic [REG_W-1:0] load_dst;
        slot_t            br;
        if ((decode_q[0].kind == KIND_LOAD) || (decode_q[1].kind == KIND_LOAD))
        begin
            load_dst = (decode_q[0].kind == KIND_LOAD) ? decode_q[0].dst : decode_q[1].dst;
            if (reads_register(fetch_q[0], load_dst) || reads_register(fetch_q[1], load_dst))
            begin
                return CAUSE_LOAD_USE;
            end
        end
        if (!fetch_full)
        begin
            return CAUSE_NONE;
        end
        if (decode_q[0].kind == KIND_BRANCH)
        begin
            br = decode_q[0];
        end
        else if (decode_q[1].kind == KIND_BRANCH)
        begin
            br = decode_q[1];
        end
        else
        begin
            return CAUSE_NONE;
        end
        return (fetch_q[0].pc != PC_W'(br.pc + PC_STEP)) ? CAUSE_CONTROL : CAUSE_NONE;
    endfunction

    // split the decode pair into alu and memory slots, memory op goes to the memory slot
    task automatic issue_decode(logic [CAUSE_W-1:0] cause);
        slot_t      alu;
        slot_t      mem;
        slot_pair_t p;
        alu = decode_q[0];
        mem = decode_q[1];
        if (touches_memory(decode_q[0].kind))
        begin
            alu = decode_q[1];
            mem = decode_q[0];
        end
        p.alu_kind = alu.kind;
        p.alu_pc   = alu.pc;
        p.mem_kind = mem.kind;
        p.mem_pc   = mem.pc;
        p.cause    = cause;
        p.last     = 1'b0;
        if (step_pairs.size() < MAX_RESULTS)
        begin
            step_pairs.push_back(p);
        end
    endtask

    // one pipe advance, plus the bubble issue if a hazard shows up
    task automatic advance_pipe(slot_t a, slot_t b, bit valid);
        logic [CAUSE_W-1:0] cause;
        issue_decode(CAUSE_NONE);
        decode_q   = fetch_q;
        fetch_q[0] = a;
        fetch_q[1] = b;
        fetch_full = valid;
        cause = bubble_reason();
        if (cause != CAUSE_NONE)
        begin
            issue_decode(cause);
            decode_q[0] = NOP_SLOT;
            decode_q[1] = NOP_SLOT;
        end
    endtask

    // all slot pairs that one accepted instruction causes
    task automatic compute_issue_pairs(slot_t x, bit eot);
        step_pairs.delete();
        if (!held_full)
        begin
            held_slot = x;
            held_full = 1'b1;
        end
        else if (pairable(held_slot, x))
        begin
            advance_pipe(held_slot, x, 1'b1);
            held_full = 1'b0;
        end
        else
        begin
            advance_pipe(held_slot, NOP_SLOT, 1'b1);
            held_slot = x;
        end
        if (eot)
        begin
            if (held_full)
            begin
                advance_pipe(held_slot, NOP_SLOT, 1'b1);
                held_full = 1'b0;
            end
            repeat (DRAIN_CYCLES)
            begin
                advance_pipe(NOP_SLOT, NOP_SLOT, 1'b0);
            end
        end
        if (step_pairs.size() != 0)
        begin
            step_pairs[step_pairs.size() - 1].last = 1'b1;
        end
        foreach (step_pairs[i])
        begin
            expected_pairs.push_back(step_pairs[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver: random ready, with a long hold-off counted here on request
    // ------------------------------------------------------------------------
    int holds_served;
    int hold_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_bus.ready <= 1'b0;
            holds_served    <= 0;
            hold_left       <= 0;
        end
        else if (holds_served != hold_requests)
        begin
            // start of a long stall, the block has to fill up and push back
            holds_served    <= hold_requests;
            hold_left       <= HOLD_CYCLES;
            issue_bus.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            issue_bus.ready <= 1'b0;
        end
        else
        begin
            issue_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // result check: every output transfer against the oldest expected pair
    // ------------------------------------------------------------------------
    function automatic void compare_field(string label, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        slot_pair_t want;
        if (rst_n && issue_bus.valid && issue_bus.ready)
        begin
            if (expected_pairs.size() == 0)
            begin
                $display("%0t ns: unexpected transfer, expected none, actual alu %0h/%0h mem %0h/%0h cause %0d last %0b",
                         $time, issue_bus.alu_slot_kind, issue_bus.alu_slot_pc,
                         issue_bus.mem_slot_kind, issue_bus.mem_slot_pc,
                         issue_bus.bubble_cause, issue_bus.last_cycle);
                mismatch_count++;
            end
            else
            begin
                want = expected_pairs.pop_front();
                compare_field("alu_slot_kind", want.alu_kind, issue_bus.alu_slot_kind);
                compare_field("alu_slot_pc",   want.alu_pc,   issue_bus.alu_slot_pc);
                compare_field("mem_slot_kind", want.mem_kind, issue_bus.mem_slot_kind);
                compare_field("mem_slot_pc",   want.mem_pc,   issue_bus.mem_slot_pc);
                compare_field("bubble_cause",  want.cause,    issue_bus.bubble_cause);
                compare_field("last_cycle",    want.last,     issue_bus.last_cycle);
            end
        end
    end

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one instruction transfer; valid stays up afterwards so back-to-back
    // sends with no idle draw keep the input busy every cycle
    task automatic send_instr(slot_t s, bit eot);
        while ($urandom_range(99) < src_idle_pct)
        begin
            instr_bus.valid <= 1'b0;
            @(posedge clk);
        end
        instr_bus.valid        <= 1'b1;
        instr_bus.instr_kind   <= s.kind;
        instr_bus.src_reg_a    <= s.src_a;
        instr_bus.src_reg_b    <= s.src_b;
        instr_bus.dest_reg     <= s.dst;
        instr_bus.instr_pc     <= s.pc;
        instr_bus.end_of_trace <= eot;
        do
        begin
            @(posedge clk);
        end
        while (!instr_bus.ready);
        compute_issue_pairs(s, eot);
    endtask

    task automatic send_fields(logic [KIND_W-1:0] k, logic [REG_W-1:0] sa,
                               logic [REG_W-1:0] sb, logic [REG_W-1:0] d,
                               logic [PC_W-1:0] pc, bit eot);
        slot_t s;
        s.kind  = k;
        s.src_a = sa;
        s.src_b = sb;
        s.dst   = d;
        s.pc    = pc;
        send_instr(s, eot);
    endtask

    // sender stops and waits until every owed pair has come out
    task automatic wait_for_quiet();
        instr_bus.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_pairs.size() != 0);
    endtask

    // mostly a small register pool so dependences and load-use hazards are common
    function automatic logic [REG_W-1:0] pick_reg();
        if ($urandom_range(99) < 85)
        begin
            return REG_W'($urandom_range(7));
        end
        return REG_W'($urandom_range(255));
    endfunction

    // plausible program: mostly sequential pcs, some short jumps, a few wild ones
    task automatic random_instr(output slot_t s);
        int r;
        r = $urandom_range(99);
        if (r < 3)
        begin
            s.kind = KIND_W'($urandom_range(KIND_UNKNOWN_HI, KIND_UNKNOWN_LO));
        end
        else if (r < 30)
        begin
            s.kind = KIND_W'($urandom_range(KIND_STORE, KIND_LOAD));
        end
        else
        begin
            s.kind = KIND_W'($urandom_range(KIND_JR, KIND_NOP));
        end
        s.src_a = pick_reg();
        s.src_b = pick_reg();
        s.dst   = pick_reg();
        r = $urandom_range(99);
        if (r < 80)
        begin
            s.pc = program_pc;
        end
        else if (r < 95)
        begin
            s.pc = program_pc + PC_W'($urandom_range(64, 1) * 4);
        end
        else
        begin
            s.pc = PC_W'($urandom());
        end
        program_pc = s.pc + PC_STEP;
    endtask

    task automatic run_random_stream(int count);
        slot_t s;
        for (int i = 0; i < count; i++)
        begin
            random_instr(s);
            send_instr(s, $urandom_range(9) == 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // pairing rules, store pair refusal, extreme registers
    task automatic test_pairing();
        send_fields(KIND_ITYPE,   8'd1,   8'd2,   8'd3,   32'h0000_0100, 1'b0);
        send_fields(KIND_LOAD,    8'd4,   8'd0,   8'd5,   32'h0000_0104, 1'b0); // pairs
        send_fields(KIND_STORE,   8'd5,   8'd6,   8'd0,   32'h0000_0108, 1'b0); // load-use
        send_fields(KIND_STORE,   8'd7,   8'd8,   8'd0,   32'h0000_010C, 1'b0); // two stores
        send_fields(KIND_RTYPE,   8'd255, 8'd255, 8'd255, 32'h0000_0110, 1'b0);
        // reads the rtype destination, but the rtype has already paired; final with nothing held
        send_fields(KIND_LOAD,    8'd255, 8'd0,   8'd9,   32'h0000_0114, 1'b1);
        wait_for_quiet();
    endtask

    // control ops never lead a pair; branch target mismatch and pc wrap
    task automatic test_control();
        send_fields(KIND_BRANCH,  8'd1,   8'd2,   8'd0,   32'h0000_0200, 1'b0);
        send_fields(KIND_STORE,   8'd1,   8'd2,   8'd0,   32'h0000_0300, 1'b0); // mismatch
        send_fields(KIND_JUMP,    8'd0,   8'd0,   8'd0,   32'h0000_0304, 1'b0);
        send_fields(KIND_JR,      8'd3,   8'd0,   8'd0,   32'h0000_0400, 1'b0);
        send_fields(KIND_LOAD,    8'd3,   8'd0,   8'd4,   32'h0000_0500, 1'b0);
        // branch reads the load destination, and sits at the top of the pc space
        send_fields(KIND_BRANCH,  8'd4,   8'd4,   8'd0,   32'hFFFF_FFFC, 1'b0);
        // pc + 4 wraps to zero, so no mismatch here
        send_fields(KIND_NOP,     8'd0,   8'd0,   8'd0,   32'h0000_0000, 1'b1);
        wait_for_quiet();
    endtask

    // special, unknown kinds, all-ones and alternating fields, final with nothing held
    task automatic test_odd_kinds();
        send_fields(KIND_SPECIAL,    8'h00, 8'hFF, 8'h0F, 32'h0000_0010, 1'b0);
        send_fields(KIND_UNKNOWN_HI, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);
        send_fields(KIND_UNKNOWN_LO, 8'hAA, 8'h55, 8'h5A, 32'h5555_5555, 1'b0);
        send_fields(KIND_LOAD,       8'h5A, 8'hA5, 8'hAA, 32'hAAAA_AAAA, 1'b0); // pairs
        send_fields(KIND_NOP,        8'h00, 8'h00, 8'h00, 32'h0000_0000, 1'b1);
        send_fields(KIND_ITYPE,      8'h12, 8'h34, 8'h56, 32'h0000_1000, 1'b1);
        wait_for_quiet();
    endtask

    // receiver stalls for a long time while the sender keeps offering
    task automatic test_backpressure();
        src_idle_pct = 0;
        hold_requests++;
        run_random_stream(40);
        wait_for_quiet();
    endtask

    task automatic test_random_phase(int src_pct, int sink_pct, int count);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        run_random_stream(count);
        wait_for_quiet();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                  <= 1'b0;
        instr_bus.valid        <= 1'b0;
        instr_bus.instr_kind   <= KIND_NOP;
        instr_bus.src_reg_a    <= '0;
        instr_bus.src_reg_b    <= '0;
        instr_bus.dest_reg     <= '0;
        instr_bus.instr_pc     <= '0;
        instr_bus.end_of_trace <= 1'b0;
        src_idle_pct  = 11;
        sink_idle_pct = 55;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pairing();
        test_control();
        test_odd_kinds();
        test_backpressure();
        test_random_phase(11, 55, 75);
        test_random_phase(55, 11, 75);
        test_random_phase(0, 0, 75);

        // let any late or stray transfer show up before deciding
        repeat (4 * DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_pairs.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
